@@ hdl/double_ended_queue_macros.svh @@
// assertion macros used by the double-ended queue checker
// no dependencies; take in by `include before any use
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// property checked at every rising edge outside reset
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen outside reset
`define DEQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hdl/deq_pkg.sv @@
// types and constants of the double-ended queue
// used by double_ended_queue and deq_checker; no dependencies
package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CAP
    } t_state;

endpackage

@@ hdl/deq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/double_ended_queue.sv @@
// Bounded double-ended queue of DEPTH entries held in a circular buffer in ram.
// Each input beat carries one command (insert front, insert back, remove front,
// remove back, or query) and yields exactly one output beat with the front and
// back elements after the command (zero when empty), the element count (low
// five bits), empty and full flags and a status: overflow for an insert into a
// full queue, underflow for a remove from an empty one; both leave the state
// unchanged, and undefined command codes behave as a query. Values are stored
// as DATA_WIDTH bits (at most 32 are kept). A command goes through the states
// in order: accept (S_IDLE) updates the front pointer and occupancy and writes
// the slot, S_READ reads front and back through two mirrored ram copies, and
// S_CAP captures the registered ram read into the output register once free. The input
// side is ready again as soon as the result sits in the output register, so a
// new command is taken while the previous result still waits for i_ready.
// No clearing pass is needed after reset: only occupied slots are ever shown.
// depends on deq_pkg and deq_ram
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [deq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [deq_pkg::VALUE_W-1:0]   o_front_value,
    output logic [deq_pkg::VALUE_W-1:0]   o_back_value,
    output logic [deq_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic [deq_pkg::STATUS_W-1:0]  o_status
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    // bits above the 32-bit input are always zero, so never stored
    localparam int STORE_W = (DATA_WIDTH < deq_pkg::VALUE_W) ? DATA_WIDTH
                                                             : deq_pkg::VALUE_W;

    // control state
    deq_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [OCC_W-1:0] r_occ, n_occ;
    deq_pkg::t_status r_status, n_status;
    logic             r_out_valid;

    // output register
    logic [deq_pkg::VALUE_W-1:0]  r_front_value;
    logic [deq_pkg::VALUE_W-1:0]  r_back_value;
    logic [deq_pkg::COUNT_W-1:0]  r_count;
    logic                         r_is_empty;
    logic                         r_is_full;
    deq_pkg::t_status             r_out_status;

    // handshake and strobes
    logic accept;
    logic ld_out;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;

    // pointer arithmetic
    logic [IDX_W-1:0] front_dec, front_inc, tail_idx, back_idx;
    logic [SUM_W-1:0] tail_sum;
    logic             occ_full, occ_empty;

    logic [STORE_W-1:0] front_rd, back_rd;

    assign occ_full  = (r_occ == OCC_W'(DEPTH));
    assign occ_empty = (r_occ == '0);

    // neighbors of the front slot, with wrap for any depth
    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // first free slot past the back; sum stays below twice the depth
    assign tail_sum = SUM_W'(r_front) + SUM_W'(r_occ);
    assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
    // back element, meaningful only when occupied
    assign back_idx = (tail_idx == '0) ? IDX_W'(DEPTH - 1) : tail_idx - 1'b1;

    // command decode: new pointer, occupancy, status and slot write
    always_comb begin
        n_front  = r_front;
        n_occ    = r_occ;
        n_status = deq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = tail_idx;
        case (deq_pkg::t_cmd'(i_cmd))
            deq_pkg::CMD_PUSH_FRONT: begin
                if (occ_full) begin
                    n_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    n_front = front_dec;
                    n_occ   = r_occ + 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (occ_full) begin
                    n_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    n_occ = r_occ + 1'b1;
                    wr_en = 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (occ_empty) begin
                    n_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_front = front_inc;
                    n_occ   = r_occ - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (occ_empty) begin
                    n_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_occ = r_occ - 1'b1;
                end
            end
            default: begin
                // query and undefined codes leave the state alone
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_CAP;
            end
            deq_pkg::S_CAP: begin
                if (ld_out) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        ld_out  = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            deq_pkg::S_CAP: begin
                // output register free or emptied this cycle
                ld_out = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_front <= n_front;
                r_occ   <= n_occ;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (ld_out) begin
            r_front_value <= occ_empty ? '0 : deq_pkg::VALUE_W'(front_rd);
            r_back_value  <= occ_empty ? '0 : deq_pkg::VALUE_W'(back_rd);
            r_count       <= deq_pkg::COUNT_W'(r_occ);
            r_is_empty    <= occ_empty;
            r_is_full     <= occ_full;
            r_out_status  <= r_status;
        end
    end

    // two copies written alike, one read port each: front and back
    deq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_ram_front (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value[STORE_W-1:0]),
        .i_rd_addr (r_front),
        .o_rd_data (front_rd)
    );

    deq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_ram_back (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value[STORE_W-1:0]),
        .i_rd_addr (back_idx),
        .o_rd_data (back_rd)
    );

    assign o_valid       = r_out_valid;
    assign o_front_value = r_front_value;
    assign o_back_value  = r_back_value;
    assign o_count       = r_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_status      = r_out_status;

endmodule

@@ hdl/deq_checker.sv @@
// port-level checks of the double-ended queue result channel
// depends on deq_pkg and double_ended_queue_macros.svh; bound to double_ended_queue
`include "double_ended_queue_macros.svh"

module deq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [deq_pkg::VALUE_W-1:0]   o_front_value,
    input logic [deq_pkg::VALUE_W-1:0]   o_back_value,
    input logic [deq_pkg::COUNT_W-1:0]   o_count,
    input logic                          o_is_empty,
    input logic                          o_is_full,
    input logic [deq_pkg::STATUS_W-1:0]  o_status
);

    // empty result shows no elements at all
    `DEQ_ASSERT(a_empty_zero, i_clk, i_rst_n, (o_valid && o_is_empty) |-> (o_count == '0 && o_front_value == '0 && o_back_value == '0), "empty result with data")

    // a queue is never empty and full at once
    `DEQ_ASSERT_NEVER(a_empty_full, i_clk, i_rst_n, o_valid && o_is_empty && o_is_full, "empty and full together")

    // overflow results show the queue at its full limit
    `DEQ_ASSERT(a_reject_limit, i_clk, i_rst_n, (o_valid && (o_status == deq_pkg::ST_OVERFLOW)) |-> o_is_full && !o_is_empty, "overflow while not full")

    // stalled result beat holds
    `DEQ_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_front_value) && $stable(o_back_value) && $stable(o_status)), "stalled result changed")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

@@ sim/tb_double_ended_queue.sv @@
// self-checking testbench of double_ended_queue: directed table, then random bursts
// each result beat is checked against its table row or an in-bench deque predictor; depends on deq_pkg
`timescale 1ns / 1ps

module tb_double_ended_queue;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int RAND_BEATS = 420;
    localparam int HOLD_CYCLES = 60;

    // command codes outside t_cmd, handled by the block as a query
    localparam logic [deq_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [deq_pkg::VALUE_W-1:0] front_value;
        logic [deq_pkg::VALUE_W-1:0] back_value;
        logic [deq_pkg::COUNT_W-1:0] count;
        logic                        is_empty;
        logic                        is_full;
        deq_pkg::t_status            status;
    } t_deq_view;

    typedef struct {
        logic [deq_pkg::CMD_W-1:0]   cmd;
        logic [deq_pkg::VALUE_W-1:0] value;
        int                          reps;
        bit                          typed;
        t_deq_view                   want;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [deq_pkg::CMD_W-1:0]      i_cmd;
    logic [deq_pkg::VALUE_W-1:0]    i_value;
    logic                           o_valid;
    logic                           i_ready;
    logic [deq_pkg::VALUE_W-1:0]    o_front_value;
    logic [deq_pkg::VALUE_W-1:0]    o_back_value;
    logic [deq_pkg::COUNT_W-1:0]    o_count;
    logic                           o_is_empty;
    logic                           o_is_full;
    logic [deq_pkg::STATUS_W-1:0]   o_status;

    // predictor copy of the deque
    logic [deq_pkg::VALUE_W-1:0]    ring [DEPTH];
    logic [3:0]                     head;
    logic [deq_pkg::COUNT_W-1:0]    fill;

    t_deq_view             pending_views [$];
    t_stim_row             stim_table [$];
    int                    n_mismatch;
    logic                  calm;      // no idling on either side while high
    logic                  hold_req;  // asks the result side for one long hold-off

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_status      (o_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // applies one command to the predictor deque and returns the view after it
    function automatic t_deq_view deq_step(input logic [deq_pkg::CMD_W-1:0] c,
                                           input logic [deq_pkg::VALUE_W-1:0] v);
        t_deq_view  r;
        logic [3:0] tail;
        r.status = deq_pkg::ST_OK;
        case (c)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (fill == DEPTH) begin
                    r.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    head = head - 4'd1;
                    ring[head] = v;
                    fill = fill + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    r.status = deq_pkg::ST_OVERFLOW;
                end else begin
                    ring[head + fill[3:0]] = v;
                    fill = fill + 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    head = head + 4'd1;
                    fill = fill - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (fill == 0) begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    fill = fill - 1'b1;
                end
            end
            default: ;
        endcase
        tail = head + fill[3:0] - 4'd1;
        r.front_value = (fill != 0) ? ring[head] : '0;
        r.back_value  = (fill != 0) ? ring[tail] : '0;
        r.count       = fill;
        r.is_empty    = (fill == 0);
        r.is_full     = (fill == DEPTH);
        return r;
    endfunction

    task automatic add_row(input logic [deq_pkg::CMD_W-1:0] c,
                           input logic [deq_pkg::VALUE_W-1:0] v,
                           input int n, input bit typed,
                           input logic [deq_pkg::VALUE_W-1:0] f,
                           input logic [deq_pkg::VALUE_W-1:0] b,
                           input logic [deq_pkg::COUNT_W-1:0] cnt,
                           input deq_pkg::t_status st);
        t_stim_row row;
        row.cmd   = c;
        row.value = v;
        row.reps  = n;
        row.typed = typed;
        row.want.front_value = f;
        row.want.back_value  = b;
        row.want.count       = cnt;
        row.want.is_empty    = (cnt == 0);
        row.want.is_full     = (cnt == DEPTH);
        row.want.status      = st;
        stim_table.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [deq_pkg::VALUE_W-1:0] want,
                               input logic [deq_pkg::VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_mismatch++;
        end
    endtask

    // offers one beat, entered and left at a rising edge; valid stays high for the next
    // beat unless an idle gap is drawn
    task automatic send_beat(input logic [deq_pkg::CMD_W-1:0] c,
                             input logic [deq_pkg::VALUE_W-1:0] v,
                             input bit typed, input t_deq_view want);
        int        gap;
        t_deq_view got_view;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 21) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        got_view = deq_step(c, v);
        pending_views.push_back(typed ? want : got_view);
    endtask

    // waits with valid low until no result is outstanding
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_views.size() != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // result side: checks each beat, then draws ready for the next cycle
    initial begin
        int        hold_left;
        bit        hold_done;
        t_deq_view want;
        hold_left = 0;
        hold_done = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_views.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected", $time);
                    n_mismatch++;
                end else begin
                    want = pending_views.pop_front();
                    check_field("front_value", want.front_value, o_front_value);
                    check_field("back_value", want.back_value, o_back_value);
                    check_field("count", deq_pkg::VALUE_W'(want.count),
                                deq_pkg::VALUE_W'(o_count));
                    check_field("is_empty", deq_pkg::VALUE_W'(want.is_empty),
                                deq_pkg::VALUE_W'(o_is_empty));
                    check_field("is_full", deq_pkg::VALUE_W'(want.is_full),
                                deq_pkg::VALUE_W'(o_is_full));
                    check_field("status", deq_pkg::VALUE_W'(want.status),
                                deq_pkg::VALUE_W'(o_status));
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // command side
    initial begin
        int                        sent;
        int                        mode;
        int                        len;
        int                        r;
        logic [deq_pkg::CMD_W-1:0] c;
        t_deq_view                 none;
        t_stim_row                 row;

        none.front_value = '0;
        none.back_value  = '0;
        none.count       = '0;
        none.is_empty    = 1'b0;
        none.is_full     = 1'b0;
        none.status      = deq_pkg::ST_OK;
        n_mismatch = 0;
        for (int i = 0; i < DEPTH; i++) ring[i] = '0;
        head     = '0;
        fill     = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_cmd    = deq_pkg::CMD_QUERY;
        i_value  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty deque: query, both removes underflow, reserved codes act as a query
        add_row(deq_pkg::CMD_QUERY, 32'h0, 1, 1'b1, 32'h0, 32'h0, 5'd0, deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_POP_FRONT, 32'h0, 1, 1'b1, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_UNDERFLOW);
        add_row(deq_pkg::CMD_POP_BACK, 32'hFFFFFFFF, 1, 1'b1, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_UNDERFLOW);
        add_row(CMD_RSVD5, 32'hFFFFFFFF, 1, 1'b1, 32'h0, 32'h0, 5'd0, deq_pkg::ST_OK);
        add_row(CMD_RSVD6, 32'h12345678, 1, 1'b1, 32'h0, 32'h0, 5'd0, deq_pkg::ST_OK);
        add_row(CMD_RSVD7, 32'h0,        1, 1'b1, 32'h0, 32'h0, 5'd0, deq_pkg::ST_OK);
        // extreme values at both ends, front insert wraps the index below zero
        add_row(deq_pkg::CMD_PUSH_FRONT, 32'h0, 1, 1'b1, 32'h0, 32'h0, 5'd1,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH_BACK, 32'hFFFFFFFF, 1, 1'b1, 32'h0, 32'hFFFFFFFF, 5'd2,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH_FRONT, 32'h55555555, 1, 1'b1, 32'h55555555,
                32'hFFFFFFFF, 5'd3, deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH_BACK, 32'hAAAAAAAA, 1, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);
        // fill to the brim, insert on both ends when full, then query and remove at both ends
        add_row(deq_pkg::CMD_PUSH_BACK, 32'h80000000, 12, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH_FRONT, 32'hDEADBEEF, 1, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH_BACK, 32'hDEADBEEF, 1, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_QUERY, 32'h0, 1, 1'b0, 32'h0, 32'h0, 5'd0, deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_POP_FRONT, 32'h0, 1, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_POP_BACK, 32'h0, 1, 1'b0, 32'h0, 32'h0, 5'd0,
                deq_pkg::ST_OK);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            for (int k = 0; k < row.reps; k++) begin
                send_beat(row.cmd, row.value + k, row.typed, row.want);
            end
        end

        // random bursts: fill-heavy and drain-heavy runs walk the deque between its
        // bounds, noise bursts use every code
        sent = 0;
        while (sent < RAND_BEATS) begin
            mode = $urandom_range(9);
            len  = $urandom_range(24, 4);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (mode >= 8) begin
                    c = deq_pkg::CMD_W'($urandom_range(7));
                end else if ((mode < 4 && r < 85) || (mode >= 4 && r >= 85 && r < 95)) begin
                    c = $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
                end else if (r < 95) begin
                    c = $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
                end else begin
                    c = deq_pkg::CMD_QUERY;
                end
                if (sent == 100) hold_req <= 1'b1;
                calm <= (sent >= 300 && sent < 380);
                if (sent == 250) wait_drained();
                send_beat(c, pick_value(), 1'b0, none);
                sent++;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ double_ended_queue.f @@
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue.sv
hdl/deq_checker.sv
sim/tb_double_ended_queue.sv
